FILE: rtl/bhmt_pkg.sv
// bhmt_pkg: shared constants, register codes and a helper function of the
// binary hit-or-miss / thinning block
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package bhmt_pkg;

    // defaults of the top level parameters
    localparam int RADIUS_DEF     = 1;
    localparam int MAX_WIDTH_DEF  = 64;
    localparam int MAX_HEIGHT_DEF = 4096;
    localparam int QUEUE_DEPTH    = 2;

    // fixed field widths of the ports
    localparam int ROW_W      = 64;
    localparam int IDX_W      = 12;
    localparam int CHG_W      = 7;
    localparam int TOT_W      = 19;
    localparam int MASK_W     = 9;
    localparam int FW_W       = 7;
    localparam int FH_W       = 13;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 13;

    localparam logic [TOT_W-1:0] TOT_MAX = {TOT_W{1'b1}};

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MODE         = 3'd0,
        REG_FG_MASK      = 3'd1,
        REG_BG_MASK      = 3'd2,
        REG_FRAME_WIDTH  = 3'd3,
        REG_FRAME_HEIGHT = 3'd4
    } cfg_reg_t;

    typedef enum logic {
        MODE_HMT  = 1'b0,
        MODE_THIN = 1'b1
    } mode_t;

    // ones on the columns below the effective width
    function automatic logic [ROW_W-1:0] width_mask(input logic [FW_W-1:0] w);
        logic [ROW_W-1:0] m;
        for (int i = 0; i < ROW_W; i++) begin
            m[i] = (FW_W'(i) < w);
        end
        return m;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/bhmt_if.sv
// bhmt channel interfaces: source rows, result rows, register writes
// depends on bhmt_pkg for the field widths
`timescale 1ns / 1ps
`default_nettype none

interface bhmt_row_if;
    logic                        valid;
    logic                        ready;
    logic [bhmt_pkg::ROW_W-1:0]  row_pixels;

    modport source (output valid, output row_pixels, input ready);
    modport sink   (input valid, input row_pixels, output ready);
endinterface

interface bhmt_res_if;
    logic                        valid;
    logic                        ready;
    logic [bhmt_pkg::ROW_W-1:0]  result_row;
    logic [bhmt_pkg::IDX_W-1:0]  row_index;
    logic [bhmt_pkg::CHG_W-1:0]  row_changed;
    logic [bhmt_pkg::TOT_W-1:0]  frame_changed;
    logic                        last_row;

    modport source (output valid, output result_row, output row_index,
                    output row_changed, output frame_changed, output last_row,
                    input ready);
    modport sink   (input valid, input result_row, input row_index,
                    input row_changed, input frame_changed, input last_row,
                    output ready);
endinterface

interface bhmt_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [bhmt_pkg::CFG_IDX_W-1:0]   index;
    logic [bhmt_pkg::CFG_DATA_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

FILE: rtl/bhmt_fifo.sv
// bhmt_fifo: short job queue between the front and the back part
// no package dependency
`timescale 1ns / 1ps
`default_nettype none

module bhmt_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push_valid,
    output      logic             push_ready,
    input  wire logic [WIDTH-1:0] push_data,
    output      logic             pop_valid,
    input  wire logic             pop_ready,
    output      logic [WIDTH-1:0] pop_data
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             push, pop;

    assign push_ready = (count_reg != CW'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = mem_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/bhmt_front.sv
// bhmt_front: takes source rows, keeps the row window and frame position,
// and turns each row that has result rows due into a job of result rows to emit
// depends on bhmt_pkg and bhmt_if
`timescale 1ns / 1ps
`default_nettype none

module bhmt_front #(
    parameter int RADIUS     = bhmt_pkg::RADIUS_DEF,
    parameter int MAX_WIDTH  = bhmt_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = bhmt_pkg::MAX_HEIGHT_DEF
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    bhmt_row_if.sink                                 rows,
    input  wire logic [bhmt_pkg::FW_W-1:0]           w_eff,
    input  wire logic [bhmt_pkg::FH_W-1:0]           frame_height,
    output      logic                                push_valid,
    input  wire logic                                push_ready,
    output      logic [(2*RADIUS+1)*MAX_WIDTH + $clog2(MAX_HEIGHT)
                       + $clog2(RADIUS+2):0]         push_data
);

    localparam int DIAM  = 2 * RADIUS + 1;
    localparam int RCW   = $clog2(MAX_HEIGHT);
    localparam int CNTW  = $clog2(RADIUS + 2);
    localparam int WIN_W = DIAM * MAX_WIDTH;
    localparam int CMPW  = (RCW + 1 > bhmt_pkg::FH_W) ? RCW + 1 : bhmt_pkg::FH_W;

    logic [MAX_WIDTH-1:0] win_reg [DIAM];
    logic [MAX_WIDTH-1:0] win_next [DIAM];
    logic [RCW-1:0]       rcv_reg, rcv_next;

    logic [CMPW-1:0]      fh_x, h_eff;
    logic                 last;
    logic                 r_ge_radius;
    logic [RCW-1:0]       e_start;
    logic [CNTW-1:0]      n_emit;
    logic [MAX_WIDTH-1:0] wm;
    logic                 accept;

    assign fh_x  = CMPW'(frame_height);
    assign h_eff = (fh_x == '0) ? CMPW'(1)
                 : ((fh_x > CMPW'(MAX_HEIGHT)) ? CMPW'(MAX_HEIGHT) : fh_x);
    assign last  = (CMPW'(rcv_reg) + CMPW'(1)) >= h_eff;

    // the row RADIUS back becomes complete; the last row flushes the rest
    assign r_ge_radius = (rcv_reg >= RCW'(RADIUS));
    assign e_start     = r_ge_radius ? rcv_reg - RCW'(RADIUS) : '0;
    assign n_emit      = last ? CNTW'(rcv_reg - e_start) + CNTW'(1)
                       : (r_ge_radius ? CNTW'(1) : '0);

    assign wm     = bhmt_pkg::width_mask(w_eff)[MAX_WIDTH-1:0];
    assign accept = rows.valid && rows.ready;

    assign rows.ready = push_ready;
    assign push_valid = rows.valid && (n_emit != '0);

    always_comb
    begin
        win_next[0] = rows.row_pixels[MAX_WIDTH-1:0] & wm;
        for (int k = 1; k < DIAM; k++)
        begin
            win_next[k] = win_reg[k-1];
        end
        rcv_next = last ? '0 : rcv_reg + RCW'(1);
    end

    always_comb
    begin
        for (int k = 0; k < DIAM; k++)
        begin
            push_data[k*MAX_WIDTH +: MAX_WIDTH] = win_next[k];
        end
        push_data[WIN_W +: RCW]          = e_start;
        push_data[WIN_W + RCW +: CNTW]   = n_emit;
        push_data[WIN_W + RCW + CNTW]    = last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rcv_reg <= '0;
        end
        else if (accept)
        begin
            rcv_reg <= rcv_next;
        end
    end

    // rows outside the frame are never looked at, so the window needs no clear
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            for (int k = 0; k < DIAM; k++)
            begin
                win_reg[k] <= win_next[k];
            end
        end
    end

endmodule

`default_nettype wire

FILE: rtl/bhmt_back.sv
// bhmt_back: matches the structuring element for each queued result row,
// counts changed pixels and drives the result register
// depends on bhmt_pkg and bhmt_if
`timescale 1ns / 1ps
`default_nettype none

module bhmt_back #(
    parameter int RADIUS     = bhmt_pkg::RADIUS_DEF,
    parameter int MAX_WIDTH  = bhmt_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = bhmt_pkg::MAX_HEIGHT_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              job_valid,
    output      logic                              job_pop,
    input  wire logic [(2*RADIUS+1)*MAX_WIDTH + $clog2(MAX_HEIGHT)
                       + $clog2(RADIUS+2):0]       job_data,
    input  wire bhmt_pkg::mode_t                   mode,
    input  wire logic [bhmt_pkg::MASK_W-1:0]       fg_mask,
    input  wire logic [bhmt_pkg::MASK_W-1:0]       bg_mask,
    input  wire logic [bhmt_pkg::FW_W-1:0]         w_eff,
    bhmt_res_if.source                             results
);

    localparam int DIAM  = 2 * RADIUS + 1;
    localparam int RCW   = $clog2(MAX_HEIGHT);
    localparam int CNTW  = $clog2(RADIUS + 2);
    localparam int WIN_W = DIAM * MAX_WIDTH;

    logic [MAX_WIDTH-1:0] win [DIAM];
    logic [RCW-1:0]       e_start, e;
    logic [CNTW-1:0]      n_emit, d;
    logic                 job_last, final_row;

    logic [CNTW-1:0]      j_reg, j_next;
    logic [MAX_WIDTH-1:0] row_sel [DIAM];
    logic [DIAM-1:0]      row_ok;
    logic [MAX_WIDTH-1:0] src, hits, wm, res, diff;
    logic [bhmt_pkg::CHG_W-1:0] ch;
    logic [bhmt_pkg::TOT_W:0]   sum;
    logic [bhmt_pkg::TOT_W-1:0] total_reg, total_next, total_sat;
    logic                 emit;

    logic                              out_valid_reg, out_valid_next;
    logic [bhmt_pkg::ROW_W-1:0]        result_reg;
    logic [bhmt_pkg::IDX_W-1:0]        index_reg;
    logic [bhmt_pkg::CHG_W-1:0]        changed_reg;
    logic [bhmt_pkg::TOT_W-1:0]        frame_reg;
    logic                              last_reg;

    always_comb
    begin
        for (int k = 0; k < DIAM; k++)
        begin
            win[k] = job_data[k*MAX_WIDTH +: MAX_WIDTH];
        end
    end

    assign e_start  = job_data[WIN_W +: RCW];
    assign n_emit   = job_data[WIN_W + RCW +: CNTW];
    assign job_last = job_data[WIN_W + RCW + CNTW];

    // d is how many rows the emitted row sits behind the newest one;
    // outside a flush the emitted row is always RADIUS rows back
    assign e         = e_start + RCW'(j_reg);
    assign d         = job_last ? (n_emit - CNTW'(1) - j_reg) : CNTW'(RADIUS);
    assign final_row = job_last && (d == '0);

    // pick the window row for each element row, dropping rows off the frame
    always_comb
    begin
        for (int a = 0; a < DIAM; a++)
        begin
            row_ok[a]  = (a <= int'(d) + RADIUS)
                      && ((a >= RADIUS) || (int'(e) >= RADIUS - a));
            row_sel[a] = '0;
            for (int k = 0; k < DIAM; k++)
            begin
                if (k == int'(d) + RADIUS - a)
                begin
                    row_sel[a] = win[k];
                end
            end
        end
        src = '0;
        for (int k = 0; k < DIAM; k++)
        begin
            if (k == int'(d))
            begin
                src = win[k];
            end
        end
    end

    // one match lane per column
    always_comb
    begin
        int  b;
        int  xx;
        logic hit;
        hits = '0;
        for (int x = 0; x < MAX_WIDTH; x++)
        begin
            hit = 1'b1;
            for (int a = 0; a < DIAM; a++)
            begin
                for (int c = 0; c < DIAM; c++)
                begin
                    b  = a * DIAM + c;
                    xx = x + c - RADIUS;
                    if ((b < bhmt_pkg::MASK_W) && (xx >= 0) && (xx < MAX_WIDTH))
                    begin
                        if (row_ok[a] && (xx < int'(w_eff)))
                        begin
                            if ((fg_mask[b] && !row_sel[a][xx])
                                || (bg_mask[b] && row_sel[a][xx]))
                            begin
                                hit = 1'b0;
                            end
                        end
                    end
                end
            end
            hits[x] = hit && (x < int'(w_eff));
        end
    end

    assign wm = bhmt_pkg::width_mask(w_eff)[MAX_WIDTH-1:0];

    always_comb
    begin
        if (mode == bhmt_pkg::MODE_THIN)
        begin
            res  = src & ~hits & wm;
            diff = src & hits & wm;
        end
        else
        begin
            res  = hits & wm;
            diff = (res ^ src) & wm;
        end
    end

    // popcount as byte counts summed in a second level
    always_comb
    begin
        logic [bhmt_pkg::ROW_W-1:0] dv;
        logic [3:0]                 bc;
        dv = bhmt_pkg::ROW_W'(diff);
        ch = '0;
        for (int g = 0; g < bhmt_pkg::ROW_W / 8; g++)
        begin
            bc = '0;
            for (int i = 0; i < 8; i++)
            begin
                bc = bc + 4'(dv[g*8 + i]);
            end
            ch = ch + bhmt_pkg::CHG_W'(bc);
        end
    end

    assign sum       = {1'b0, total_reg} + (bhmt_pkg::TOT_W + 1)'(ch);
    assign total_sat = (sum > {1'b0, bhmt_pkg::TOT_MAX}) ? bhmt_pkg::TOT_MAX
                     : sum[bhmt_pkg::TOT_W-1:0];

    assign emit    = job_valid && (!out_valid_reg || results.ready);
    assign job_pop = emit && (j_reg == n_emit - CNTW'(1));

    always_comb
    begin
        j_next         = j_reg;
        total_next     = total_reg;
        out_valid_next = out_valid_reg;
        if (results.ready)
        begin
            out_valid_next = 1'b0;
        end
        if (emit)
        begin
            out_valid_next = 1'b1;
            j_next         = job_pop ? '0 : j_reg + CNTW'(1);
            total_next     = final_row ? '0 : total_sat;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            j_reg         <= '0;
            total_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            j_reg         <= j_next;
            total_reg     <= total_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            result_reg  <= bhmt_pkg::ROW_W'(res);
            index_reg   <= bhmt_pkg::IDX_W'(e);
            changed_reg <= ch;
            frame_reg   <= total_sat;
            last_reg    <= final_row;
        end
    end

    assign results.valid         = out_valid_reg;
    assign results.result_row    = result_reg;
    assign results.row_index     = index_reg;
    assign results.row_changed   = changed_reg;
    assign results.frame_changed = frame_reg;
    assign results.last_row      = last_reg;

endmodule

`default_nettype wire

FILE: rtl/binary_hit_or_miss_thinning.sv
// binary_hit_or_miss_thinning: top level with the register file, the front
// part, the job queue and the back part
// depends on bhmt_pkg, bhmt_if, bhmt_fifo, bhmt_front and bhmt_back
`timescale 1ns / 1ps
`default_nettype none

// Binary hit-or-miss transform and thinning over a raster stream. Each item
// on rows is one image row (bit x = pixel x); each item on results is one
// processed row with its row number, the number of pixels that changed
// against the source row, the running changed total of the frame
// (saturating at 19 bits) and a flag on the frame's final row. The square
// structuring element of side 2*RADIUS+1 is set by fg_mask (must be set) and
// bg_mask (must be clear); neighbours outside the frame always match. Results
// trail the source by RADIUS rows, and the last row of the frame (from
// frame_height) flushes the remaining rows, so that row yields up to
// RADIUS+1 results. Rate: one row per cycle; the front part takes a row
// every cycle while the job queue has room, and the back part produces one
// result row per cycle while results are taken, so a frame's last row holds
// it until all are out. Each result passes the job queue and result register.
// Registers are written through cfg (always ready), by the user only while
// no row is in flight (block does not enforce); no clearing pass after reset.
module binary_hit_or_miss_thinning #(
    parameter int RADIUS     = bhmt_pkg::RADIUS_DEF,
    parameter int MAX_WIDTH  = bhmt_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = bhmt_pkg::MAX_HEIGHT_DEF
) (
    input wire logic    clk,
    input wire logic    rst_n,
    bhmt_row_if.sink    rows,
    bhmt_res_if.source  results,
    bhmt_cfg_if.sink    cfg
);

    localparam int DIAM  = 2 * RADIUS + 1;
    localparam int RCW   = $clog2(MAX_HEIGHT);
    localparam int CNTW  = $clog2(RADIUS + 2);
    localparam int JOB_W = DIAM * MAX_WIDTH + RCW + CNTW + 1;
    localparam logic [bhmt_pkg::FW_W-1:0] MAXW = bhmt_pkg::FW_W'(MAX_WIDTH);

    // configuration registers
    bhmt_pkg::mode_t                mode_reg;
    logic [bhmt_pkg::MASK_W-1:0]    fg_reg;
    logic [bhmt_pkg::MASK_W-1:0]    bg_reg;
    logic [bhmt_pkg::FW_W-1:0]      fw_reg;
    logic [bhmt_pkg::FH_W-1:0]      fh_reg;
    logic [bhmt_pkg::FW_W-1:0]      w_eff;

    // job queue between front and back
    logic             push_valid, push_ready;
    logic [JOB_W-1:0] push_data;
    logic             job_valid, job_pop;
    logic [JOB_W-1:0] job_data;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= bhmt_pkg::MODE_HMT;
            fg_reg   <= '0;
            bg_reg   <= '0;
            fw_reg   <= bhmt_pkg::FW_W'(64);
            fh_reg   <= bhmt_pkg::FH_W'(64);
        end
        else if (cfg.valid && cfg.ready)
        begin
            unique case (bhmt_pkg::cfg_reg_t'(cfg.index))
                bhmt_pkg::REG_MODE:         mode_reg <= bhmt_pkg::mode_t'(cfg.data[0]);
                bhmt_pkg::REG_FG_MASK:      fg_reg   <= cfg.data[bhmt_pkg::MASK_W-1:0];
                bhmt_pkg::REG_BG_MASK:      bg_reg   <= cfg.data[bhmt_pkg::MASK_W-1:0];
                bhmt_pkg::REG_FRAME_WIDTH:  fw_reg   <= cfg.data[bhmt_pkg::FW_W-1:0];
                bhmt_pkg::REG_FRAME_HEIGHT: fh_reg   <= cfg.data[bhmt_pkg::FH_W-1:0];
                default: ;  // writes past the register list are dropped
            endcase
        end
    end

    // zero width acts as one column, anything wider than the store as full
    assign w_eff = (fw_reg == '0) ? bhmt_pkg::FW_W'(1)
                 : ((fw_reg > MAXW) ? MAXW : fw_reg);

    // front: window of the newest rows, frame position, job per row with results due
    bhmt_front #(
        .RADIUS     (RADIUS),
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .rows         (rows),
        .w_eff        (w_eff),
        .frame_height (fh_reg),
        .push_valid   (push_valid),
        .push_ready   (push_ready),
        .push_data    (push_data)
    );

    // queue lets the front keep taking rows while results wait downstream
    bhmt_fifo #(
        .WIDTH (JOB_W),
        .DEPTH (bhmt_pkg::QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (job_valid),
        .pop_ready  (job_pop),
        .pop_data   (job_data)
    );

    // back: per-column matching, changed counts, result register
    bhmt_back #(
        .RADIUS     (RADIUS),
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (job_valid),
        .job_pop   (job_pop),
        .job_data  (job_data),
        .mode      (mode_reg),
        .fg_mask   (fg_reg),
        .bg_mask   (bg_reg),
        .w_eff     (w_eff),
        .results   (results)
    );

endmodule

`default_nettype wire

FILE: rtl/bhmt_checker.sv
// bhmt_checker: assertions on the result port of the top level, bound to it
// depends on bhmt_pkg and binary_hit_or_miss_thinning
`timescale 1ns / 1ps
`default_nettype none

module bhmt_checker (
    input wire logic                        clk,
    input wire logic                        rst_n,
    input wire logic                        out_valid,
    input wire logic                        out_ready,
    input wire logic [bhmt_pkg::ROW_W-1:0]  result_row,
    input wire logic [bhmt_pkg::CHG_W-1:0]  row_changed,
    input wire logic [bhmt_pkg::TOT_W-1:0]  frame_changed,
    input wire logic                        last_row
);

    // a stalled item keeps its result row, frame total and last flag
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(result_row)
            && $stable(frame_changed) && $stable(last_row))
        else $error("result item changed while stalled");

    // no row holds more than 64 changed pixels
    a_row_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> row_changed <= 7'd64)
        else $error("row changed count out of range");

    // the frame total includes the current row
    a_total_covers: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> frame_changed >= bhmt_pkg::TOT_W'(row_changed))
        else $error("frame total below row count");

    // nothing is offered straight out of reset
    a_reset_idle: assert property (@(posedge clk)
        !rst_n |=> !out_valid)
        else $error("result valid after reset");

endmodule

bind binary_hit_or_miss_thinning bhmt_checker u_bhmt_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .out_valid     (results.valid),
    .out_ready     (results.ready),
    .result_row    (results.result_row),
    .row_changed   (results.row_changed),
    .frame_changed (results.frame_changed),
    .last_row      (results.last_row)
);

`default_nettype wire

FILE: dv/tb.sv
`timescale 1ns / 1ps
// tb: self-checking bench for binary_hit_or_miss_thinning, a directed table of
// register writes and rows followed by random frames under handshake pressure
// depends on bhmt_pkg, bhmt_if and the rtl top level

module tb;

    // geometry of the structuring element, matching the dut defaults
    localparam int RADIUS     = bhmt_pkg::RADIUS_DEF;
    localparam int DIAM       = 2 * RADIUS + 1;
    localparam int MAX_WIDTH  = bhmt_pkg::MAX_WIDTH_DEF;
    localparam int MAX_HEIGHT = bhmt_pkg::MAX_HEIGHT_DEF;

    localparam int ROW_W      = bhmt_pkg::ROW_W;
    localparam int IDX_W      = bhmt_pkg::IDX_W;
    localparam int CHG_W      = bhmt_pkg::CHG_W;
    localparam int TOT_W      = bhmt_pkg::TOT_W;
    localparam int MASK_W     = bhmt_pkg::MASK_W;
    localparam int FW_W       = bhmt_pkg::FW_W;
    localparam int FH_W       = bhmt_pkg::FH_W;
    localparam int CFG_DATA_W = bhmt_pkg::CFG_DATA_W;

    // run control
    localparam int HOLD_OFF       = 8;     // quiet cycles before a register write
    localparam int TAIL_CYCLES    = 20;    // extra cycles after the last result
    localparam int WATCHDOG_LIMIT = 2000;  // cycles with no item moving anywhere
    localparam int MAX_REPORTS    = 10;
    localparam int PHASES         = 8;
    localparam int PHASE_ITEMS    = 25;

    typedef enum int {
        IDLE_NONE,
        IDLE_SRC,
        IDLE_SNK,
        IDLE_BOTH
    } pressure_t;

    // one result item, field for field
    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic [IDX_W-1:0] idx;
        logic [CHG_W-1:0] chg;
        logic [TOT_W-1:0] tot;
        logic             last;
    } result_t;

    // one line of the directed table: a register write or a row item
    typedef struct {
        logic                  is_cfg;
        bhmt_pkg::cfg_reg_t    reg_idx;
        logic [CFG_DATA_W-1:0] value;
        logic [ROW_W-1:0]      pixels;
        logic                  typed;
        result_t               want;
    } stim_t;

    logic clk;
    logic rst_n;

    bhmt_row_if row_ch ();
    bhmt_res_if res_ch ();
    bhmt_cfg_if cfg_ch ();

    binary_hit_or_miss_thinning dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .rows    (row_ch),
        .results (res_ch),
        .cfg     (cfg_ch)
    );

    // predictor copy of the registers
    bhmt_pkg::mode_t   cur_mode;
    logic [MASK_W-1:0] cur_fg;
    logic [MASK_W-1:0] cur_bg;
    logic [FW_W-1:0]   cur_width;
    logic [FH_W-1:0]   cur_height;

    // predictor copy of the state: window[0] is the newest row
    logic [ROW_W-1:0] window [DIAM];
    int               rows_in;
    int               rows_out;
    int unsigned      frame_total;

    result_t expected_results[$];

    int   errors;
    int   idle_cycles;
    int   src_gap_pct;
    int   snk_stall_pct;
    logic stream_open;   // rows sent since the last drain

    // free-running clock, 8 ns period
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // hit bits of frame row e while row r is the newest one in the window;
    // rows above the top, not yet received or gone from the window, and
    // columns outside the width all count as matching
    function automatic logic [ROW_W-1:0] hit_mask(input int e, input int r, input int w);
        logic [ROW_W-1:0] hits;
        logic             hit;
        logic             f;
        logic             g;
        logic             p;
        int               y;
        int               xx;
        int               b;
        hits = '0;
        for (int x = 0; x < w; x++)
        begin
            hit = 1'b1;
            for (int dy = -RADIUS; dy <= RADIUS; dy++)
            begin
                y = e + dy;
                if (y >= 0 && y <= r && r - y < DIAM)
                begin
                    for (int dx = -RADIUS; dx <= RADIUS; dx++)
                    begin
                        b  = (dy + RADIUS) * DIAM + dx + RADIUS;
                        f  = cur_fg[b];
                        g  = cur_bg[b];
                        xx = x + dx;
                        if ((f || g) && xx >= 0 && xx < w)
                        begin
                            p = window[r - y][xx];
                            if ((f && !p) || (g && p))
                                hit = 1'b0;
                        end
                    end
                end
            end
            hits[x] = hit;
        end
        return hits;
    endfunction

    // advance the predictor by one accepted row and queue the result rows
    function automatic void predict_results(input logic [ROW_W-1:0] px);
        int               w;
        int               h;
        int               r;
        int               n;
        int               e;
        int               ch;
        logic [ROW_W-1:0] wm;
        logic [ROW_W-1:0] src;
        logic [ROW_W-1:0] hits;
        logic [ROW_W-1:0] res;
        logic             last;
        result_t          item;
        // out-of-range sizes are clamped
        w = (cur_width == 0) ? 1 : (cur_width > MAX_WIDTH) ? MAX_WIDTH : int'(cur_width);
        h = (cur_height == 0) ? 1 : (cur_height > MAX_HEIGHT) ? MAX_HEIGHT : int'(cur_height);
        wm = (w >= ROW_W) ? {ROW_W{1'b1}} : ((ROW_W'(1) << w) - ROW_W'(1));
        r = rows_in;
        // checked against the current height, so a lowered height ends the frame
        last = (rows_in + 1 >= h);
        for (int k = DIAM - 1; k > 0; k--)
            window[k] = window[k - 1];
        window[0] = px & wm;
        n = 0;
        // lag of RADIUS rows, the frame's last row flushes the rest
        while (n < RADIUS + 1 && rows_out <= r && (last || rows_out + RADIUS <= r))
        begin
            e    = rows_out;
            src  = window[r - e];
            hits = hit_mask(e, r, w);
            if (cur_mode == bhmt_pkg::MODE_HMT)
            begin
                res = hits & wm;
                ch  = $countones((res ^ src) & wm);
            end
            else
            begin
                res = src & ~hits & wm;
                ch  = $countones(src & hits & wm);
            end
            frame_total = frame_total + ch;
            if (frame_total > bhmt_pkg::TOT_MAX)
                frame_total = bhmt_pkg::TOT_MAX;
            item.row  = res;
            item.idx  = e[IDX_W-1:0];
            item.chg  = ch[CHG_W-1:0];
            item.tot  = frame_total[TOT_W-1:0];
            item.last = last && (e == r);
            expected_results.push_back(item);
            rows_out++;
            n++;
        end
        if (last)
        begin
            rows_in     = 0;
            rows_out    = 0;
            frame_total = 0;
            foreach (window[k])
                window[k] = '0;
        end
        else
        begin
            rows_in++;
        end
    endfunction

    // row content with a spread of densities so that masks actually hit
    function automatic logic [ROW_W-1:0] rand_row();
        logic [ROW_W-1:0] a;
        logic [ROW_W-1:0] b;
        a = {$urandom, $urandom};
        b = {$urandom, $urandom};
        case ($urandom_range(5))
            0:       return a & b;
            1:       return a | b;
            2:       return '0;
            3:       return {ROW_W{1'b1}};
            default: return a;
        endcase
    endfunction

    function automatic stim_t cfg_entry(input bhmt_pkg::cfg_reg_t idx,
                                        input logic [CFG_DATA_W-1:0] val);
        stim_t s;
        s.is_cfg  = 1'b1;
        s.reg_idx = idx;
        s.value   = val;
        s.pixels  = '0;
        s.typed   = 1'b0;
        s.want    = '0;
        return s;
    endfunction

    function automatic stim_t row_entry(input logic [ROW_W-1:0] px);
        stim_t s;
        s.is_cfg  = 1'b0;
        s.reg_idx = bhmt_pkg::REG_MODE;
        s.value   = '0;
        s.pixels  = px;
        s.typed   = 1'b0;
        s.want    = '0;
        return s;
    endfunction

    // row item whose single result is written out by hand
    function automatic stim_t typed_entry(input logic [ROW_W-1:0] px, input result_t want);
        stim_t s;
        s       = row_entry(px);
        s.typed = 1'b1;
        s.want  = want;
        return s;
    endfunction

    task automatic report_error(input string what, input result_t want, input result_t got);
        errors++;
        if (errors <= MAX_REPORTS)
            $display("%s: exp row=%h idx=%0d chg=%0d tot=%0d last=%0b, %s%h%s%0d%s%0d%s%0d%s%0b",
                     what, want.row, want.idx, want.chg, want.tot, want.last,
                     "got row=", got.row, " idx=", got.idx, " chg=", got.chg,
                     " tot=", got.tot, " last=", got.last);
    endtask

    // stop the row stream and wait until the block has gone quiet
    task automatic settle();
        @(negedge clk);
        row_ch.valid <= 1'b0;
        while (expected_results.size() != 0)
            @(negedge clk);
        // a row without a result may still be in flight
        repeat (HOLD_OFF) @(negedge clk);
        stream_open = 1'b0;
    endtask

    task automatic write_reg(input bhmt_pkg::cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val);
        if (stream_open)
            settle();
        @(negedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        do @(posedge clk); while (!cfg_ch.ready);
        // predictor takes the write at the same edge; extra data bits are dropped
        case (idx)
            bhmt_pkg::REG_MODE:         cur_mode   = bhmt_pkg::mode_t'(val[0]);
            bhmt_pkg::REG_FG_MASK:      cur_fg     = val[MASK_W-1:0];
            bhmt_pkg::REG_BG_MASK:      cur_bg     = val[MASK_W-1:0];
            bhmt_pkg::REG_FRAME_WIDTH:  cur_width  = val[FW_W-1:0];
            bhmt_pkg::REG_FRAME_HEIGHT: cur_height = val[FH_W-1:0];
            default:                    ;
        endcase
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // offer one row item, with a random gap in front of it
    task automatic send_row(input logic [ROW_W-1:0] px, input logic typed, input result_t want);
        @(negedge clk);
        while ($urandom_range(99) < src_gap_pct)
        begin
            row_ch.valid <= 1'b0;
            @(negedge clk);
        end
        row_ch.valid      <= 1'b1;
        row_ch.row_pixels <= px;
        stream_open = 1'b1;
        do @(posedge clk); while (!row_ch.ready);
        predict_results(px);
        // a hand-written result takes the place of the predicted one
        if (typed)
            expected_results[$] = want;
    endtask

    // receiver: ready changes only at the falling edge
    initial
    begin
        res_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            res_ch.ready <= ($urandom_range(99) >= snk_stall_pct);
        end
    end

    // result checker: every accepted result against the oldest expectation
    always @(posedge clk)
    begin : check_results
        result_t got;
        result_t want;
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            got.row  = res_ch.result_row;
            got.idx  = res_ch.row_index;
            got.chg  = res_ch.row_changed;
            got.tot  = res_ch.frame_changed;
            got.last = res_ch.last_row;
            if (expected_results.size() == 0)
            begin
                report_error("unexpected result", '0, got);
            end
            else
            begin
                want = expected_results.pop_front();
                if (got.row !== want.row || got.idx !== want.idx || got.chg !== want.chg ||
                    got.tot !== want.tot || got.last !== want.last)
                    report_error("result mismatch", want, got);
            end
        end
    end

    // watchdog: cycles in which no item moves on any channel
    always @(posedge clk)
    begin
        if (!rst_n)
            idle_cycles <= 0;
        else if ((row_ch.valid && row_ch.ready) || (res_ch.valid && res_ch.ready) ||
                 (cfg_ch.valid && cfg_ch.ready))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("FAIL binary_hit_or_miss_thinning");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin : stimulus
        stim_t                 directed[$];
        pressure_t             pressure;
        logic [CFG_DATA_W-1:0] fg_val;
        logic [CFG_DATA_W-1:0] bg_val;
        logic [CFG_DATA_W-1:0] w_val;
        logic [CFG_DATA_W-1:0] h_val;

        // every dut input known from time zero
        rst_n             = 1'b0;
        row_ch.valid      = 1'b0;
        row_ch.row_pixels = '0;
        cfg_ch.valid      = 1'b0;
        cfg_ch.index      = bhmt_pkg::REG_MODE;
        cfg_ch.data       = '0;

        // predictor at its reset values
        cur_mode    = bhmt_pkg::MODE_HMT;
        cur_fg      = '0;
        cur_bg      = '0;
        cur_width   = FW_W'(64);
        cur_height  = FH_W'(64);
        foreach (window[k])
            window[k] = '0;
        rows_in     = 0;
        rows_out    = 0;
        frame_total = 0;

        errors        = 0;
        stream_open   = 1'b0;
        src_gap_pct   = 0;
        snk_stall_pct = 0;

        // reset defaults: empty masks, so every pixel hits
        directed.push_back(row_entry({ROW_W{1'b1}}));
        directed.push_back(typed_entry('0, result_t'{{ROW_W{1'b1}}, 12'd0, 7'd0, 19'd0, 1'b0}));
        // height lowered below the rows already taken: next row ends the frame
        directed.push_back(cfg_entry(bhmt_pkg::REG_FRAME_HEIGHT, 13'd1));
        directed.push_back(row_entry(64'h5555_5555_5555_5555));
        // one-row frames
        directed.push_back(typed_entry('0, result_t'{{ROW_W{1'b1}}, 12'd0, 7'd64, 19'd64, 1'b1}));
        directed.push_back(typed_entry({ROW_W{1'b1}},
                                       result_t'{{ROW_W{1'b1}}, 12'd0, 7'd0, 19'd0, 1'b1}));
        // thinning with the center alone in the foreground clears every set pixel
        directed.push_back(cfg_entry(bhmt_pkg::REG_MODE, CFG_DATA_W'(bhmt_pkg::MODE_THIN)));
        directed.push_back(cfg_entry(bhmt_pkg::REG_FG_MASK, 13'h0010));
        directed.push_back(row_entry(64'hDEAD_BEEF_0123_4567));
        // overlapping masks with junk above the mask bits: nothing can hit
        directed.push_back(cfg_entry(bhmt_pkg::REG_BG_MASK, 13'h1FFF));
        directed.push_back(typed_entry({ROW_W{1'b1}},
                                       result_t'{{ROW_W{1'b1}}, 12'd0, 7'd0, 19'd0, 1'b1}));
        // zero width acts as one column
        directed.push_back(cfg_entry(bhmt_pkg::REG_FRAME_WIDTH, 13'd0));
        directed.push_back(typed_entry({ROW_W{1'b1}},
                                       result_t'{64'h1, 12'd0, 7'd0, 19'd0, 1'b1}));
        // oversize width and zero height clamp
        directed.push_back(cfg_entry(bhmt_pkg::REG_FRAME_WIDTH, 13'd127));
        directed.push_back(cfg_entry(bhmt_pkg::REG_FRAME_HEIGHT, 13'd0));
        directed.push_back(row_entry(64'h8000_0000_0000_0001));
        // edge detector element on a three-row, eight-column frame, both modes
        directed.push_back(cfg_entry(bhmt_pkg::REG_MODE, CFG_DATA_W'(bhmt_pkg::MODE_HMT)));
        directed.push_back(cfg_entry(bhmt_pkg::REG_FG_MASK, 13'h01D0));
        directed.push_back(cfg_entry(bhmt_pkg::REG_BG_MASK, 13'h0007));
        directed.push_back(cfg_entry(bhmt_pkg::REG_FRAME_WIDTH, 13'd8));
        directed.push_back(cfg_entry(bhmt_pkg::REG_FRAME_HEIGHT, 13'd3));
        directed.push_back(row_entry(64'hFFFF_FF00));
        directed.push_back(row_entry(64'h3C));
        directed.push_back(row_entry(64'hFF));
        directed.push_back(cfg_entry(bhmt_pkg::REG_MODE, CFG_DATA_W'(bhmt_pkg::MODE_THIN)));
        directed.push_back(row_entry(64'h18));
        directed.push_back(row_entry(64'h3C));
        directed.push_back(row_entry(64'h7E));
        // full foreground, full width, oversize height; the frame stays open
        directed.push_back(cfg_entry(bhmt_pkg::REG_MODE, CFG_DATA_W'(bhmt_pkg::MODE_HMT)));
        directed.push_back(cfg_entry(bhmt_pkg::REG_FG_MASK, 13'h01FF));
        directed.push_back(cfg_entry(bhmt_pkg::REG_BG_MASK, 13'h0000));
        directed.push_back(cfg_entry(bhmt_pkg::REG_FRAME_WIDTH, 13'd64));
        directed.push_back(cfg_entry(bhmt_pkg::REG_FRAME_HEIGHT, 13'd8191));
        directed.push_back(row_entry({ROW_W{1'b1}}));
        directed.push_back(row_entry({ROW_W{1'b1}}));
        directed.push_back(row_entry(64'h0F0F_F0F0_0F0F_F0F0));
        directed.push_back(row_entry(64'h7FFF_FFFF_FFFF_FFFE));

        repeat (10) @(negedge clk);
        rst_n = 1'b1;

        // directed part, no idling
        foreach (directed[i])
        begin
            if (directed[i].is_cfg)
                write_reg(directed[i].reg_idx, directed[i].value);
            else
                send_row(directed[i].pixels, directed[i].typed, directed[i].want);
        end

        // random part: new settings each phase, pressure cycles through its modes
        for (int p = 0; p < PHASES; p++)
        begin
            pressure = pressure_t'(p % 4);
            case (pressure)
                IDLE_NONE:
                begin
                    src_gap_pct   = 0;
                    snk_stall_pct = 0;
                end
                IDLE_SRC:
                begin
                    src_gap_pct   = 76;
                    snk_stall_pct = 0;
                end
                IDLE_SNK:
                begin
                    src_gap_pct   = 0;
                    snk_stall_pct = 76;
                end
                default:
                begin
                    src_gap_pct   = 12;
                    snk_stall_pct = 12;
                end
            endcase

            write_reg(bhmt_pkg::REG_MODE, CFG_DATA_W'($urandom_range(1)));

            case ($urandom_range(5))
                0:       fg_val = '0;
                1:       fg_val = CFG_DATA_W'(9'h1FF);
                default: fg_val = CFG_DATA_W'($urandom_range(8191));
            endcase
            write_reg(bhmt_pkg::REG_FG_MASK, fg_val);

            // mostly disjoint from the foreground, sometimes overlapping
            bg_val = CFG_DATA_W'($urandom_range(8191));
            if ($urandom_range(3) != 0)
                bg_val = bg_val & ~fg_val;
            write_reg(bhmt_pkg::REG_BG_MASK, bg_val);

            case ($urandom_range(7))
                0:       w_val = '0;
                1:       w_val = CFG_DATA_W'(64);
                2:       w_val = CFG_DATA_W'($urandom_range(127, 65));
                default: w_val = CFG_DATA_W'($urandom_range(64, 1));
            endcase
            write_reg(bhmt_pkg::REG_FRAME_WIDTH, w_val);

            // short frames mostly, so that many frame ends and flushes occur
            case ($urandom_range(9))
                0:       h_val = '0;
                1:       h_val = CFG_DATA_W'(8191);
                default: h_val = CFG_DATA_W'($urandom_range(6, 1));
            endcase
            write_reg(bhmt_pkg::REG_FRAME_HEIGHT, h_val);

            repeat (PHASE_ITEMS) send_row(rand_row(), 1'b0, '0);
        end

        // drain and let the pipeline run dry
        settle();
        repeat (TAIL_CYCLES) @(negedge clk);

        if (errors == 0)
            $display("PASS binary_hit_or_miss_thinning");
        else
            $display("FAIL binary_hit_or_miss_thinning");
        $finish;
    end

endmodule

FILE: sim.f
rtl/bhmt_pkg.sv
rtl/bhmt_if.sv
rtl/bhmt_fifo.sv
rtl/bhmt_front.sv
rtl/bhmt_back.sv
rtl/binary_hit_or_miss_thinning.sv
rtl/bhmt_checker.sv
dv/tb.sv
